FILE: src/rpr_pkg.sv
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared codes, field widths and the command bundle passed from the
// controller to the datapath of the range partition router.
// ----------------------------------------------------------------------------
package rpr_pkg;

  localparam int unsigned IN_KEY_BITS    = 32;
  localparam int unsigned OUT_BOUND_BITS = 32;
  localparam int unsigned OUT_IDX_BITS   = 4;
  localparam int unsigned CFG_BITS       = 5;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef struct packed {
    logic load_item;
    logic search;
    logic commit;
  } rpr_cmd_t;

endpackage

FILE: src/range_partition_router.sv
// ----------------------------------------------------------------------------
// range_partition_router
// Result: an item passes the search state, then the update state, where
// commit loads the result register unless a held result is stalled. A new
// item is taken only when idle or at commit (next search sees widened range).
// Reset: synchronous, active low; clears range count and bound-set flags,
// bound values are not reset. No clearing pass.
// ----------------------------------------------------------------------------
module range_partition_router import rpr_pkg::*; #(
  parameter int unsigned MAX_RANGES = 16,
  parameter int unsigned KEY_BITS   = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CFG_BITS-1:0]       cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_cmd,
  input  logic [IN_KEY_BITS-1:0]    in_key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_status,
  output logic [OUT_IDX_BITS-1:0]   out_range_index,
  output logic [OUT_BOUND_BITS-1:0] out_bound_low,
  output logic [OUT_BOUND_BITS-1:0] out_bound_high,
  output logic                      out_low_is_set,
  output logic                      out_high_is_set
);

  rpr_cmd_t cmd;

  rpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rpr_datapath #(
    .MAX_RANGES (MAX_RANGES),
    .KEY_BITS   (KEY_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .out_status      (out_status),
    .out_range_index (out_range_index),
    .out_bound_low   (out_bound_low),
    .out_bound_high  (out_bound_high),
    .out_low_is_set  (out_low_is_set),
    .out_high_is_set (out_high_is_set)
  );

  a_load_then_search: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_item |=> cmd.search)
    else $error("accepted item not followed by search");

  a_search_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.search |-> in_stall)
    else $error("input open during search");

  a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit without result");

  a_no_commit_over_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.commit)
    else $error("result overwritten while stalled");

endmodule

FILE: src/rpr_ctrl.sv
// ----------------------------------------------------------------------------
// rpr_ctrl
// Controller: sequences accept, search and commit of each item and owns the
// handshake on both channels.
// ----------------------------------------------------------------------------
module rpr_ctrl import rpr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output rpr_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   commit;
  logic   take;

  assign commit = (state_r == ST_UPDATE) && !(out_valid_r && out_stall);
  assign in_stall = !((state_r == ST_IDLE) || commit);
  assign take = in_valid && !in_stall;

  always_comb begin
    cmd.load_item = take;
    cmd.search    = (state_r == ST_SEARCH);
    cmd.commit    = commit;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (commit) state_nxt = take ? ST_SEARCH : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (commit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: src/rpr_datapath.sv
// ----------------------------------------------------------------------------
// rpr_datapath
// Range table, parallel containment search, fallback choice, widening of the
// chosen range and the result register.
// ----------------------------------------------------------------------------
module rpr_datapath import rpr_pkg::*; #(
  parameter int unsigned MAX_RANGES = 16,
  parameter int unsigned KEY_BITS   = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rpr_cmd_t                  cmd,
  input  logic                      cfg_wr_en,
  input  logic [CFG_BITS-1:0]       cfg_wr_data,
  input  logic                      in_cmd,
  input  logic [IN_KEY_BITS-1:0]    in_key,
  output logic                      out_status,
  output logic [OUT_IDX_BITS-1:0]   out_range_index,
  output logic [OUT_BOUND_BITS-1:0] out_bound_low,
  output logic [OUT_BOUND_BITS-1:0] out_bound_high,
  output logic                      out_low_is_set,
  output logic                      out_high_is_set
);

  localparam int unsigned KW    = (KEY_BITS < IN_KEY_BITS) ? KEY_BITS : IN_KEY_BITS;
  localparam int unsigned IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);

  logic [KW-1:0]         key_r;
  logic                  insert_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      cnt_new;
  logic [KW-1:0]         lo_bound_r [MAX_RANGES];
  logic [KW-1:0]         hi_bound_r [MAX_RANGES];
  logic [MAX_RANGES-1:0] lo_valid_r;
  logic [MAX_RANGES-1:0] hi_valid_r;

  logic [MAX_RANGES-1:0] hit_nxt;
  logic [MAX_RANGES-1:0] hit_r;
  logic                  below_r;
  logic                  above_r;
  logic                  fb_ok_r;
  logic [IDX_W-1:0]      last_idx;

  logic [IDX_W-1:0]      enc_idx;
  logic [IDX_W-1:0]      sel_idx;
  logic                  any_hit;
  logic                  found;
  logic [KW-1:0]         e_lb;
  logic [KW-1:0]         e_hb;
  logic                  e_lv;
  logic                  e_hv;
  logic [KW-1:0]         new_lb;
  logic [KW-1:0]         new_hb;
  logic                  new_lv;
  logic                  new_hv;
  logic                  lo_eq;
  logic                  hi_eq;
  logic                  wr_en;

  logic                      status_r;
  logic [OUT_IDX_BITS-1:0]   idx_out_r;
  logic [OUT_BOUND_BITS-1:0] lb_out_r;
  logic [OUT_BOUND_BITS-1:0] hb_out_r;
  logic                      lv_out_r;
  logic                      hv_out_r;

  always_comb begin
    if (int'(cfg_wr_data) > int'(MAX_RANGES)) cnt_new = CNT_W'(MAX_RANGES);
    else cnt_new = CNT_W'(cfg_wr_data);
  end

  assign last_idx = IDX_W'(count_r - CNT_W'(1));

  // hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      key_r    <= in_key[KW-1:0];
      insert_r <= (in_cmd == CMD_INSERT);
    end
  end

  always_comb begin
    for (int i = 0; i < int'(MAX_RANGES); i++) begin
      hit_nxt[i] = (i < int'(count_r)) &&
                   (!lo_valid_r[i] || !hi_valid_r[i] ||
                    ((lo_bound_r[i] <= key_r) && (key_r <= hi_bound_r[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      hit_r   <= hit_nxt;
      below_r <= key_r < lo_bound_r[0];
      above_r <= key_r > hi_bound_r[last_idx];
      fb_ok_r <= insert_r && (count_r != '0);
    end
  end

  // lowest hit wins
  always_comb begin
    enc_idx = '0;
    for (int i = int'(MAX_RANGES) - 1; i >= 0; i--) begin
      if (hit_r[i]) enc_idx = IDX_W'(i);
    end
  end

  assign any_hit = |hit_r;
  assign found   = any_hit || (fb_ok_r && (below_r || above_r));

  always_comb begin
    priority if (any_hit) sel_idx = enc_idx;
    else if (below_r) sel_idx = '0;
    else sel_idx = last_idx;
  end

  assign e_lb  = lo_bound_r[sel_idx];
  assign e_hb  = hi_bound_r[sel_idx];
  assign e_lv  = lo_valid_r[sel_idx];
  assign e_hv  = hi_valid_r[sel_idx];
  assign lo_eq = e_lv && (e_lb == key_r);
  assign hi_eq = e_hv && (e_hb == key_r);

  always_comb begin
    new_lb = e_lb;
    new_hb = e_hb;
    new_lv = e_lv;
    new_hv = e_hv;
    if (insert_r && !(lo_eq || hi_eq)) begin
      priority if (!e_lv || (key_r < e_lb)) begin
        new_lb = key_r;
        new_lv = 1'b1;
      end else if (!e_hv || (key_r > e_hb)) begin
        new_hb = key_r;
        new_hv = 1'b1;
      end
    end
  end

  assign wr_en = cmd.commit && found && insert_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lo_bound_r[sel_idx] <= new_lb;
      hi_bound_r[sel_idx] <= new_hb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      lo_valid_r <= '0;
      hi_valid_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        count_r <= cnt_new;
        for (int i = 0; i < int'(MAX_RANGES); i++) begin
          if (i >= int'(cnt_new)) begin
            lo_valid_r[i] <= 1'b0;
            hi_valid_r[i] <= 1'b0;
          end
        end
      end else if (wr_en) begin
        lo_valid_r[sel_idx] <= new_lv;
        hi_valid_r[sel_idx] <= new_hv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (found) begin
        status_r  <= STATUS_OK;
        idx_out_r <= OUT_IDX_BITS'(sel_idx);
        lb_out_r  <= new_lv ? OUT_BOUND_BITS'(new_lb) : '0;
        hb_out_r  <= new_hv ? OUT_BOUND_BITS'(new_hb) : '0;
        lv_out_r  <= new_lv;
        hv_out_r  <= new_hv;
      end else begin
        status_r  <= STATUS_MISS;
        idx_out_r <= '0;
        lb_out_r  <= '0;
        hb_out_r  <= '0;
        lv_out_r  <= 1'b0;
        hv_out_r  <= 1'b0;
      end
    end
  end

  assign out_status      = status_r;
  assign out_range_index = idx_out_r;
  assign out_bound_low   = lb_out_r;
  assign out_bound_high  = hb_out_r;
  assign out_low_is_set  = lv_out_r;
  assign out_high_is_set = hv_out_r;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for range_partition_router. A queue-fed driver
// sends lookups and inserts, and a clocked monitor checks every result
// against a predictor that keeps its own copy of the range table. Both
// sides idle at random. The range count is rewritten between phases,
// including the empty table and the saturating write.
// ----------------------------------------------------------------------------
module tb;
  import rpr_pkg::*;

  localparam int unsigned TBL_DEPTH    = 16;
  localparam int unsigned LOG_LIMIT    = 10;
  localparam int unsigned PHASE_ITEMS  = 78;
  localparam int unsigned POOL_DEPTH   = 64;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct packed {
    logic                   cmd;
    logic [IN_KEY_BITS-1:0] key;
  } route_item_t;

  typedef struct packed {
    logic                      status;
    logic [OUT_IDX_BITS-1:0]   index;
    logic [OUT_BOUND_BITS-1:0] lo;
    logic [OUT_BOUND_BITS-1:0] hi;
    logic                      lo_set;
    logic                      hi_set;
  } route_res_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_BITS-1:0]       cfg_wr_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_cmd = CMD_LOOKUP;
  logic [IN_KEY_BITS-1:0]    in_key = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_status;
  logic [OUT_IDX_BITS-1:0]   out_range_index;
  logic [OUT_BOUND_BITS-1:0] out_bound_low;
  logic [OUT_BOUND_BITS-1:0] out_bound_high;
  logic                      out_low_is_set;
  logic                      out_high_is_set;

  route_item_t            item_q[$];
  route_res_t             route_exp_q[$];
  logic [IN_KEY_BITS-1:0] key_pool[$];

  bit [IN_KEY_BITS-1:0] tbl_lo [TBL_DEPTH];
  bit [IN_KEY_BITS-1:0] tbl_hi [TBL_DEPTH];
  bit                   tbl_lo_set [TBL_DEPTH];
  bit                   tbl_hi_set [TBL_DEPTH];
  int unsigned          tbl_used = 0;

  bit          steady = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  int unsigned n_err = 0;
  int unsigned n_items = 0;
  int unsigned n_inserts = 0;
  int unsigned n_miss = 0;
  int unsigned n_fallback = 0;
  int unsigned n_results = 0;
  int unsigned n_writes = 0;

  range_partition_router i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_range_index (out_range_index),
    .out_bound_low   (out_bound_low),
    .out_bound_high  (out_bound_high),
    .out_low_is_set  (out_low_is_set),
    .out_high_is_set (out_high_is_set)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic void route_predict(input logic cmd, input logic [IN_KEY_BITS-1:0] key);
    route_res_t  r;
    bit          found;
    int unsigned idx;
    int unsigned last;
    int unsigned i;
    r = '0;
    found = 1'b0;
    idx = 0;
    n_items++;
    if (cmd == CMD_INSERT) n_inserts++;
    for (i = 0; i < tbl_used; i++) begin
      if (!found && (!tbl_lo_set[i] || !tbl_hi_set[i] ||
                     (tbl_lo[i] <= key && key <= tbl_hi[i]))) begin
        found = 1'b1;
        idx = i;
      end
    end
    if (!found && cmd == CMD_INSERT && tbl_used > 0) begin
      last = tbl_used - 1;
      if (key < tbl_lo[0]) begin
        found = 1'b1;
        idx = 0;
        n_fallback++;
      end else if (key > tbl_hi[last]) begin
        found = 1'b1;
        idx = last;
        n_fallback++;
      end
    end
    if (!found) begin
      r.status = STATUS_MISS;
      n_miss++;
    end else begin
      if (cmd == CMD_INSERT &&
          !((tbl_lo_set[idx] && tbl_lo[idx] == key) ||
            (tbl_hi_set[idx] && tbl_hi[idx] == key))) begin
        if (!tbl_lo_set[idx] || key < tbl_lo[idx]) begin
          tbl_lo[idx] = key;
          tbl_lo_set[idx] = 1'b1;
        end else if (!tbl_hi_set[idx] || key > tbl_hi[idx]) begin
          tbl_hi[idx] = key;
          tbl_hi_set[idx] = 1'b1;
        end
      end
      r.status = STATUS_OK;
      r.index  = idx[OUT_IDX_BITS-1:0];
      r.lo     = tbl_lo_set[idx] ? tbl_lo[idx] : '0;
      r.hi     = tbl_hi_set[idx] ? tbl_hi[idx] : '0;
      r.lo_set = tbl_lo_set[idx];
      r.hi_set = tbl_hi_set[idx];
    end
    route_exp_q.push_back(r);
  endfunction

  function automatic void push_item(input logic cmd, input logic [IN_KEY_BITS-1:0] key);
    route_item_t it;
    it.cmd = cmd;
    it.key = key;
    item_q.push_back(it);
    key_pool.push_back(key);
    if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
  endfunction

  function automatic logic [IN_KEY_BITS-1:0] pick_key();
    logic [IN_KEY_BITS-1:0] k;
    case ($urandom_range(0, 9))
      0: k = '0;
      1: k = '1;
      2, 3: k = $urandom_range(0, 4095);
      4, 5: begin
        if (key_pool.size() != 0)
          k = key_pool[$urandom_range(0, key_pool.size() - 1)] + $urandom_range(0, 2) - 1;
        else
          k = $urandom;
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  task automatic wait_drain();
    do @(negedge clk); while (item_q.size() != 0 || in_valid || route_exp_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_range_count(input logic [CFG_BITS-1:0] value);
    int unsigned n;
    int unsigned i;
    n = (value > TBL_DEPTH) ? TBL_DEPTH : value;
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    for (i = n; i < TBL_DEPTH; i++) begin
      tbl_lo_set[i] = 1'b0;
      tbl_hi_set[i] = 1'b0;
    end
    tbl_used = n;
    n_writes++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_items
    route_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        route_predict(in_cmd, in_key);
        in_gap = draw_gap();
      end
      if (in_gap == 0 && item_q.size() != 0) begin
        nxt = item_q.pop_front();
        in_cmd   <= nxt.cmd;
        in_key   <= nxt.key;
        in_valid <= 1'b1;
      end else begin
        if (in_gap != 0) in_gap--;
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    route_res_t want;
    route_res_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        got = '{out_status, out_range_index, out_bound_low, out_bound_high,
                out_low_is_set, out_high_is_set};
        if (route_exp_q.size() == 0) begin
          n_err++;
          if (n_err <= LOG_LIMIT) $display("tb: result %0d arrived with none expected", n_results);
        end else begin
          want = route_exp_q.pop_front();
          if (got !== want) begin
            n_err++;
            if (n_err <= LOG_LIMIT) begin
              $display("tb: result %0d exp st=%0d idx=%0d lo=%h hi=%h ls=%0d hs=%0d",
                       n_results, want.status, want.index, want.lo, want.hi,
                       want.lo_set, want.hi_set);
              $display("tb: result %0d got st=%0d idx=%0d lo=%h hi=%h ls=%0d hs=%0d",
                       n_results, got.status, got.index, got.lo, got.hi,
                       got.lo_set, got.hi_set);
            end
          end
        end
        out_hold = draw_gap();
      end
      if (out_hold != 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [CFG_BITS-1:0] sizes[10];
    int unsigned         p;
    int unsigned         j;
    int unsigned         spin;
    sizes = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd16, 5'd1, 5'd9, 5'd17, 5'd4, 5'd16};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table after reset: every item misses
    push_item(CMD_LOOKUP, '0);
    push_item(CMD_INSERT, '1);
    push_item(CMD_INSERT, 32'h8000_0000);
    wait_drain();

    write_range_count(5'd2);
    push_item(CMD_INSERT, 32'd100);
    push_item(CMD_INSERT, 32'd100);
    push_item(CMD_INSERT, 32'd50);
    push_item(CMD_INSERT, 32'd200);
    push_item(CMD_LOOKUP, 32'd150);
    push_item(CMD_LOOKUP, 32'd300);
    push_item(CMD_INSERT, 32'd300);
    push_item(CMD_INSERT, '1);
    push_item(CMD_LOOKUP, 32'd10);
    push_item(CMD_INSERT, 32'd10);
    push_item(CMD_INSERT, 32'd250);
    push_item(CMD_LOOKUP, '1);
    push_item(CMD_INSERT, '0);
    push_item(CMD_INSERT, 32'd200);
    push_item(CMD_INSERT, 32'd150);
    wait_drain();

    // saturating count keeps both filled ranges
    write_range_count(5'd31);
    push_item(CMD_LOOKUP, 32'd300);
    wait_drain();

    // drop range 1, fall back past the top of range 0, then bring range 1 back empty
    write_range_count(5'd1);
    push_item(CMD_INSERT, 32'h7000_0000);
    push_item(CMD_LOOKUP, 32'h7000_0000);
    wait_drain();
    write_range_count(5'd2);
    push_item(CMD_LOOKUP, 32'h7000_0001);
    wait_drain();

    for (p = 0; p < 10; p++) begin
      write_range_count(sizes[p]);
      steady = ($urandom_range(0, 2) == 0);
      for (j = 0; j < PHASE_ITEMS; j++)
        push_item(($urandom_range(0, 9) < 6) ? CMD_INSERT : CMD_LOOKUP, pick_key());
      wait_drain();
    end
    steady = 1'b0;

    do @(negedge clk); while (item_q.size() != 0 || in_valid);
    spin = 0;
    while (route_exp_q.size() != 0 && spin < DRAIN_CYCLES) begin
      @(negedge clk);
      spin++;
    end
    repeat (10) @(posedge clk);
    if (route_exp_q.size() != 0) begin
      n_err += route_exp_q.size();
      $display("tb: %0d results never arrived", route_exp_q.size());
    end

    $display("tb: %0d items checked (%0d inserts) across %0d range count writes",
             n_items, n_inserts, n_writes);
    $display("tb: %0d misses, %0d edge-range fallbacks, %0d mismatches",
             n_miss, n_fallback, n_err);
    if (n_err == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: range_partition_router.f
src/rpr_pkg.sv
src/rpr_ctrl.sv
src/rpr_datapath.sv
src/range_partition_router.sv
tb/tb.sv
